/* rtl/bignum_multiplier_macros.svh */
// Assertion macros for the multiplier RTL
`ifndef BIGNUM_MULTIPLIER_MACROS_SVH
`define BIGNUM_MULTIPLIER_MACROS_SVH
// assert that a implies b in the same cycle
`define BNM_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define BNM_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* rtl/bnm_pkg.sv */
// Types and constants for the big integer multiplier
package bnm_pkg;
  localparam int unsigned WordW = 64;

  // first and last partial-product phase of one row step
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LAST  = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] a_word;
    logic [WordW-1:0] b_word;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] product_word;
    logic             last_word;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MUL,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  // per-cycle control from the sequencer to the cell row
  typedef struct packed {
    logic       load;   // shift an operand word into the row
    logic       step;   // one multiply-accumulate phase in every cell
    logic       flush;  // add each link to its carry with no multiply
    logic [1:0] phase;  // which 32x32 partial product this step phase uses
  } row_ctrl_t;
endpackage

/* rtl/bignum_multiplier.sv */
// Top level: operand loading, cell row and product sequencing
// Sequence: after the beat with the last operand words the row runs N row steps
// (one 32x32 multiply per cell a cycle), then a carry flush, then the 2N
// product beats follow one per cycle while out_ready is high.
// A new operand pair is taken only after the last product beat; input waits
// while the row multiplies, flushes or emits. Reset (synchronous) returns to loading.
module bignum_multiplier #(
  parameter int unsigned OPERAND_WORDS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bnm_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bnm_pkg::out_beat_t out_data
);
  `include "bignum_multiplier_macros.svh"

  localparam int unsigned W  = bnm_pkg::WordW;
  localparam int unsigned N  = OPERAND_WORDS;
  localparam int unsigned CW = $clog2(2*N+1);
  localparam int unsigned BW = (N > 1) ? $clog2(N) : 1;

  bnm_pkg::state_t   state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [1:0]        phase, phase_next;
  logic [W-1:0]      b_mem [N];
  logic [W-1:0]      b_cur;
  logic [W-1:0]      low_sh [N];   // finished low product words
  bnm_pkg::row_ctrl_t ctrl;
  logic [W-1:0]      a_link [N+1];
  logic [W-1:0]      acc_link [N+1];
  logic [W-1:0]      car_link [N];
  logic              in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // B operand store, read one word per step
  always_ff @(posedge clk) begin
    if (in_fire) b_mem[cnt[BW-1:0]] <= in_data.b_word;
    // forward the word written this cycle when it is also the next one read
    if (in_fire && cnt_next[BW-1:0] == cnt[BW-1:0]) b_cur <= in_data.b_word;
    else b_cur <= b_mem[cnt_next[BW-1:0]];
  end

  // cell row: A enters at the top end; accumulator links shift downward
  assign a_link[N]   = in_data.a_word;
  assign acc_link[N] = '0;
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_row
      logic [W-1:0] acc_src;
      // cell g adds cell g+1's accumulator and its own carry on the first step phase and on a flush
      assign acc_src = acc_link[g+1];
      bnm_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .a_in     (a_link[g+1]),
        .a_out    (a_link[g]),
        .b_word   (b_cur),
        .acc_in   (acc_src),
        .acc_out  (acc_link[g]),
        .carry_out(car_link[g]),
        .carry_in (car_link[g])
      );
    end
  endgenerate

  // low product words drop out of cell 0 at each step start and at the flush, and shift out as the low half is emitted
  always_ff @(posedge clk) begin
    if ((ctrl.step && ctrl.phase == bnm_pkg::PH_FIRST) || state == bnm_pkg::ST_FLUSH) begin
      for (int k = 0; k < N - 1; k++) low_sh[k] <= low_sh[k+1];
      low_sh[N-1] <= acc_link[0];
    end else if (out_fire && state == bnm_pkg::ST_EMIT && cnt < CW'(N)) begin
      for (int k = 0; k < N - 1; k++) low_sh[k] <= low_sh[k+1];
      low_sh[N-1] <= '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bnm_pkg::ST_LOAD;
      cnt   <= '0;
      phase <= bnm_pkg::PH_FIRST;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    phase_next = phase;
    ctrl       = '0;
    in_ready   = 1'b0;
    unique case (state)
      bnm_pkg::ST_LOAD: begin
        in_ready  = 1'b1;
        ctrl.load = in_fire;
        if (in_fire) begin
          if (cnt == CW'(N - 1)) begin
            cnt_next   = '0;
            state_next = bnm_pkg::ST_MUL;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      bnm_pkg::ST_MUL: begin
        ctrl.step  = 1'b1;
        ctrl.phase = phase;
        phase_next = phase + 1'b1;
        if (phase == bnm_pkg::PH_LAST) begin
          if (cnt == CW'(N - 1)) begin
            cnt_next   = '0;
            state_next = bnm_pkg::ST_FLUSH;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      bnm_pkg::ST_FLUSH: begin
        ctrl.flush = 1'b1;
        state_next = bnm_pkg::ST_EMIT;
      end
      bnm_pkg::ST_EMIT: begin
        if (out_fire) begin
          if (cnt >= CW'(N)) ctrl.flush = 1'b1;
          if (cnt == CW'(2*N - 1)) begin
            cnt_next   = '0;
            state_next = bnm_pkg::ST_LOAD;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: state_next = bnm_pkg::ST_LOAD;
    endcase
  end

  assign out_valid = (state == bnm_pkg::ST_EMIT);
  assign out_data.product_word = (cnt < CW'(N)) ? low_sh[0] : acc_link[0];
  assign out_data.last_word    = (cnt == CW'(2*N - 1));

  `BNM_ASSERT_IMP(a_no_in_busy, clk, rst, state != bnm_pkg::ST_LOAD, !in_ready)
  `BNM_ASSERT_IMP(a_last_emit, clk, rst, out_data.last_word && out_valid,
                  state == bnm_pkg::ST_EMIT)
  `BNM_ASSERT_NEXT(a_done_load, clk, rst, out_fire && out_data.last_word,
                   state == bnm_pkg::ST_LOAD && cnt == '0)
endmodule

/* rtl/bnm_cell.sv */
// One cell of the multiplier row: holds an A word and an accumulator word
module bnm_cell (
  input  logic                      clk,
  input  bnm_pkg::row_ctrl_t        ctrl,
  input  logic [bnm_pkg::WordW-1:0] a_in,
  output logic [bnm_pkg::WordW-1:0] a_out,
  input  logic [bnm_pkg::WordW-1:0] b_word,
  input  logic [bnm_pkg::WordW-1:0] acc_in,
  output logic [bnm_pkg::WordW-1:0] acc_out,
  output logic [bnm_pkg::WordW-1:0] carry_out,
  input  logic [bnm_pkg::WordW-1:0] carry_in
);
  localparam int unsigned W = bnm_pkg::WordW;
  localparam int unsigned H = W / 2;

  logic [W-1:0]   a_reg;
  logic [W-1:0]   acc;
  logic [W-1:0]   carry;
  logic [H-1:0]   a_half;
  logic [H-1:0]   b_half;
  logic [W-1:0]   part;
  logic [2*W-1:0] link_sum;
  logic [2*W-1:0] addend;
  logic [2*W-1:0] sum;

  // one 32x32 partial product per phase: low*low, low*high, high*low, high*high;
  // a*b + acc + carry never exceeds 2W bits, so no partial sum overflows
  always_comb begin
    a_half   = ctrl.phase[1] ? a_reg[W-1:H] : a_reg[H-1:0];
    b_half   = ctrl.phase[0] ? b_word[W-1:H] : b_word[H-1:0];
    part     = a_half * b_half;
    link_sum = {{W{1'b0}}, acc_in} + {{W{1'b0}}, carry_in};
    if (ctrl.phase == bnm_pkg::PH_FIRST) begin
      addend = {{W{1'b0}}, part};
      sum    = link_sum + addend;
    end else if (ctrl.phase == bnm_pkg::PH_LAST) begin
      addend = {part, {W{1'b0}}};
      sum    = {carry, acc} + addend;
    end else begin
      addend = {{H{1'b0}}, part, {H{1'b0}}};
      sum    = {carry, acc} + addend;
    end
  end

  // load shifts A and clears acc and carry; the first step phase takes the upper neighbor's
  // accumulator (word shift), later phases add into the cell's own pair; flush adds links
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_reg <= a_in;
      acc   <= '0;
      carry <= '0;
    end else if (ctrl.step) begin
      {carry, acc} <= sum;
    end else if (ctrl.flush) begin
      {carry, acc} <= link_sum;
    end
  end

  assign a_out     = a_reg;
  assign acc_out   = acc;
  assign carry_out = carry;
endmodule
